// ===== src/guide_sequence_prefilter_macros.svh =====
// Assertion macros shared by the guide sequence prefilter modules
`ifndef GUIDE_SEQUENCE_PREFILTER_MACROS_SVH
`define GUIDE_SEQUENCE_PREFILTER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge outside reset
`define GSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("guide prefilter assertion failed");
// Next-cycle implication, checked on every rising edge outside reset
`define GSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("guide prefilter assertion failed");
`else
`define GSP_ASSERT_IMP(label, ante, cons)
`define GSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/gsp_pkg.sv =====
// Shared constants and stage types for the guide sequence prefilter
package gsp_pkg;

    // Guide geometry
    localparam int GUIDE_LEN = 23;
    localparam int AT_WINDOW = 20;
    localparam int RUN_LEN   = 4;
    localparam int BASE_W    = 2;
    localparam int GUIDE_W   = BASE_W * GUIDE_LEN;

    // Base codes
    localparam logic [BASE_W-1:0] BASE_A = 2'd0;
    localparam logic [BASE_W-1:0] BASE_T = 2'd3;

    // A/T count reduction: partial sums over small groups, then a final add
    localparam int GROUP_SIZE  = 5;
    localparam int NUM_GROUPS  = (AT_WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_SUM_W = $clog2(GROUP_SIZE + 1);
    localparam int COUNT_W     = 5;

    // Percent bounds and products for the exact cross-multiplied compare
    localparam int PCT_W        = 7;
    localparam int PERCENT_FULL = 100;
    localparam int PROD_W       = PCT_W + PCT_W;

    localparam logic [PCT_W-1:0] AT_LOW_RESET  = 7'd20;
    localparam logic [PCT_W-1:0] AT_HIGH_RESET = 7'd65;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic {
        REG_AT_LOW  = 1'b0,
        REG_AT_HIGH = 1'b1
    } t_reg_idx;

    // Stage 1: per-base flags
    typedef struct packed {
        logic                 valid;
        logic [AT_WINDOW-1:0] at_flags;
        logic [GUIDE_LEN-1:0] t_flags;
        logic                 end_fail;
    } t_s1;

    // Stage 2: partial counts and run result
    typedef struct packed {
        logic                                   valid;
        logic [NUM_GROUPS-1:0][GROUP_SUM_W-1:0] group_sums;
        logic                                   end_fail;
        logic                                   run_fail;
    } t_s2;

    // Stage 3: finished result
    typedef struct packed {
        logic               valid;
        logic               end_base_fail;
        logic               at_fail;
        logic               t_run_fail;
        logic [COUNT_W-1:0] at_count;
        logic               all_pass;
    } t_result;

    // Bound registers as seen by the pipeline
    typedef struct packed {
        logic [PCT_W-1:0] at_low;
        logic [PCT_W-1:0] at_high;
    } t_bounds;

endpackage

// ===== src/gsp_regs.sv =====
// APB-style configuration registers holding the A/T percent bounds
module gsp_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output gsp_pkg::t_bounds                o_bounds
);

    logic [gsp_pkg::PCT_W-1:0] r_at_low;
    logic [gsp_pkg::PCT_W-1:0] r_at_high;
    logic                      wr_en;
    gsp_pkg::t_reg_idx         reg_idx;

    // Decode the word address; byte offsets within a word are ignored
    assign reg_idx = gsp_pkg::t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Write the addressed bound
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_low  <= gsp_pkg::AT_LOW_RESET;
            r_at_high <= gsp_pkg::AT_HIGH_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                gsp_pkg::REG_AT_LOW:  r_at_low  <= pwdata[gsp_pkg::PCT_W-1:0];
                gsp_pkg::REG_AT_HIGH: r_at_high <= pwdata[gsp_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed bound
    always_comb begin
        case (reg_idx)
            gsp_pkg::REG_AT_LOW:  prdata = gsp_pkg::APB_DATA_W'(r_at_low);
            gsp_pkg::REG_AT_HIGH: prdata = gsp_pkg::APB_DATA_W'(r_at_high);
            default:              prdata = '0;
        endcase
    end

    assign o_bounds.at_low  = r_at_low;
    assign o_bounds.at_high = r_at_high;

endmodule

// ===== src/gsp_decode.sv =====
// Stage 1: decode each base into A/T and T flags and check the end bases
module gsp_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [gsp_pkg::GUIDE_W-1:0]  i_guide_bases,
    output gsp_pkg::t_s1                 o_s1
);

    gsp_pkg::t_s1 r_s1;
    gsp_pkg::t_s1 n_s1;

    // Flag every base independently
    always_comb begin
        logic [gsp_pkg::BASE_W-1:0] base;
        logic [gsp_pkg::BASE_W-1:0] first_base;
        logic [gsp_pkg::BASE_W-1:0] last_base;
        n_s1.valid = i_valid;
        for (int i = 0; i < gsp_pkg::GUIDE_LEN; i++) begin
            base = i_guide_bases[gsp_pkg::BASE_W*i +: gsp_pkg::BASE_W];
            n_s1.t_flags[i] = (base == gsp_pkg::BASE_T);
        end
        for (int i = 0; i < gsp_pkg::AT_WINDOW; i++) begin
            base = i_guide_bases[gsp_pkg::BASE_W*i +: gsp_pkg::BASE_W];
            n_s1.at_flags[i] = (base == gsp_pkg::BASE_A) || (base == gsp_pkg::BASE_T);
        end
        first_base = i_guide_bases[gsp_pkg::BASE_W-1:0];
        last_base  = i_guide_bases[gsp_pkg::BASE_W*(gsp_pkg::GUIDE_LEN-1) +: gsp_pkg::BASE_W];
        n_s1.end_fail = (first_base == gsp_pkg::BASE_T) || (last_base == gsp_pkg::BASE_A);
    end

    // Advance the stage unless the pipeline is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== src/gsp_reduce.sv =====
// Stage 2: group partial A/T counts and the T run window search
module gsp_reduce (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  gsp_pkg::t_s1  i_s1,
    output gsp_pkg::t_s2  o_s2
);

    gsp_pkg::t_s2 r_s2;
    gsp_pkg::t_s2 n_s2;

    // Count A/T flags per group and look for a T run in every window
    always_comb begin
        logic [gsp_pkg::GROUP_SUM_W-1:0] sum;
        logic                            run;
        n_s2.valid    = i_s1.valid;
        n_s2.end_fail = i_s1.end_fail;
        for (int g = 0; g < gsp_pkg::NUM_GROUPS; g++) begin
            sum = '0;
            for (int k = 0; k < gsp_pkg::GROUP_SIZE; k++) begin
                if (g * gsp_pkg::GROUP_SIZE + k < gsp_pkg::AT_WINDOW) begin
                    sum = sum + gsp_pkg::GROUP_SUM_W'(
                        i_s1.at_flags[g * gsp_pkg::GROUP_SIZE + k]);
                end
            end
            n_s2.group_sums[g] = sum;
        end
        run = 1'b0;
        for (int w = 0; w <= gsp_pkg::GUIDE_LEN - gsp_pkg::RUN_LEN; w++) begin
            run = run | (&i_s1.t_flags[w +: gsp_pkg::RUN_LEN]);
        end
        n_s2.run_fail = run;
    end

    // Advance the stage unless the pipeline is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_adv) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

// ===== src/gsp_judge.sv =====
// Stage 3: final A/T count, bound compare and the result register
`include "guide_sequence_prefilter_macros.svh"

module gsp_judge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  gsp_pkg::t_s2      i_s2,
    input  gsp_pkg::t_bounds  i_bounds,
    output gsp_pkg::t_result  o_result
);

    gsp_pkg::t_result r_result;
    gsp_pkg::t_result n_result;

    // Add the group counts and compare 100*count against bound*window
    always_comb begin
        logic [gsp_pkg::COUNT_W-1:0] count;
        logic [gsp_pkg::PROD_W-1:0]  count_pct;
        logic [gsp_pkg::PROD_W-1:0]  low_lim;
        logic [gsp_pkg::PROD_W-1:0]  high_lim;
        count = '0;
        for (int g = 0; g < gsp_pkg::NUM_GROUPS; g++) begin
            count = count + gsp_pkg::COUNT_W'(i_s2.group_sums[g]);
        end
        count_pct = gsp_pkg::PROD_W'(count) * gsp_pkg::PROD_W'(gsp_pkg::PERCENT_FULL);
        low_lim   = gsp_pkg::PROD_W'(i_bounds.at_low) * gsp_pkg::PROD_W'(gsp_pkg::AT_WINDOW);
        high_lim  = gsp_pkg::PROD_W'(i_bounds.at_high) * gsp_pkg::PROD_W'(gsp_pkg::AT_WINDOW);
        n_result.valid         = i_s2.valid;
        n_result.end_base_fail = i_s2.end_fail;
        n_result.t_run_fail    = i_s2.run_fail;
        n_result.at_fail       = (count_pct < low_lim) || (count_pct > high_lim);
        n_result.at_count      = count;
        n_result.all_pass      = !(i_s2.end_fail || i_s2.run_fail || n_result.at_fail);
    end

    // Load the result register unless the result is still waiting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result.valid <= 1'b0;
        end else if (i_adv) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

    // The count never exceeds the window size
    `GSP_ASSERT_IMP(a_count_range, r_result.valid,
                    r_result.at_count <= gsp_pkg::COUNT_W'(gsp_pkg::AT_WINDOW))
    // A failed check always clears the summary pass flag
    `GSP_ASSERT_IMP(a_pass_excl,
                    r_result.valid && (r_result.t_run_fail || r_result.at_fail
                                       || r_result.end_base_fail),
                    !r_result.all_pass)

endmodule

// ===== src/guide_sequence_prefilter.sv =====
// Guide sequence prefilter: top level with handshake control and the three stages
//
// Screens each packed 23-base guide: flags a T first base or an A last base, an
// A/T share of the first 20 bases outside the programmed percent bounds (compared
// exactly as 100*count against bound*20), and any run of four T bases, and
// reports the A/T count and an overall pass flag. A new request is taken every
// cycle unless o_stall is high; the decode register loads on the edge that takes
// it, then the reduce and judge registers in turn; the judge register drives the
// output. When a valid result is stalled at the output the whole pipeline holds
// and o_stall is raised; no request is lost. There is no clearing pass after
// reset. The bounds are written over the APB port (low bound at address 0, high
// bound at address 4); users must write them only while no request is in flight,
// which the block does not enforce; values above one hundred are used as they are.
`include "guide_sequence_prefilter_macros.svh"

module guide_sequence_prefilter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [gsp_pkg::GUIDE_W-1:0]     i_guide_bases,
    // Result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_end_base_fail,
    output logic                            o_at_fail,
    output logic                            o_t_run_fail,
    output logic [gsp_pkg::COUNT_W-1:0]     o_at_count,
    output logic                            o_all_pass,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    gsp_pkg::t_bounds bounds;
    gsp_pkg::t_s1     s1;
    gsp_pkg::t_s2     s2;
    gsp_pkg::t_result result;
    logic             adv;

    // Hold every stage while a finished result waits downstream
    assign adv     = !(result.valid && i_stall);
    assign o_stall = !adv;

    gsp_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_bounds (bounds)
    );

    gsp_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (i_valid),
        .i_guide_bases (i_guide_bases),
        .o_s1          (s1)
    );

    gsp_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    gsp_judge u_judge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_s2     (s2),
        .i_bounds (bounds),
        .o_result (result)
    );

    // Drive the result ports from the output register
    assign o_valid         = result.valid;
    assign o_end_base_fail = result.end_base_fail;
    assign o_at_fail       = result.at_fail;
    assign o_t_run_fail    = result.t_run_fail;
    assign o_at_count      = result.at_count;
    assign o_all_pass      = result.all_pass;

    // A taken request occupies the first stage on the next cycle
    `GSP_ASSERT_NEXT(a_req_enters, i_valid && !o_stall, s1.valid)
    // Held stages keep their contents
    `GSP_ASSERT_NEXT(a_s1_hold, s1.valid && o_stall, s1.valid)
    `GSP_ASSERT_NEXT(a_s2_hold, s2.valid && o_stall, s2.valid)

endmodule
